FILE: hdl/rlm_pkg.sv
// ----------------------------------------------------------------------------
// rlm_pkg
// Shared types and constants for the block RMS level meter.
// ----------------------------------------------------------------------------
package rlm_pkg;

   // Field and datapath widths
   localparam int SAMPLE_W   = 32;
   localparam int SUM_W      = 60;
   localparam int CNT_W      = 7;
   localparam int DB_W       = 9;
   localparam int FRAC_W     = 16;
   localparam int INT_W      = 6;
   localparam int LOG_W      = INT_W + FRAC_W;
   localparam int MANT_W     = 31;
   localparam int NORM_W     = 64;
   localparam int MUL_W      = 33;
   localparam int PROD_W     = 64;
   localparam int MAG_W      = 23;
   localparam int DIFF_W     = 24;
   localparam int K_W        = 26;

   // Arithmetic constants
   localparam int SQ_SHIFT   = 8;      // square is scaled down before summing
   localparam int MANT_SHIFT = 30;     // mantissa held in Q1.30
   localparam int DB_SHIFT   = 40;     // Q16 log times Q24 scale
   localparam int LOG_OFFSET = 22;     // square units are 2^-22
   localparam int NORM_STEPS = 6;
   localparam int LOG_ITERS  = 16;
   localparam int STEP_W     = 4;

   localparam int BLOCK_WORDS_DEF = 64;

   localparam logic [K_W-1:0]            DB_K      = 26'd50504453; // 10*log10(2), Q24
   localparam logic signed [DB_W-1:0]    SILENT_DB = -9'sd240;
   localparam logic signed [DB_W-1:0]    DB_MAX    = 9'sd96;

   // Controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ACC,
      ST_NORM,
      ST_MANT,
      ST_LOG,
      ST_SWAP,
      ST_DIFF,
      ST_SCALE,
      ST_OUT
   } state_type;

   // Shared multiplier operand select
   typedef enum logic [1:0] {
      MUL_SQUARE,
      MUL_MANT,
      MUL_SCALE
   } mul_sel_type;

   // Controller to datapath
   typedef struct packed {
      mul_sel_type         mul_sel;
      logic                take;       // register sample square and last flag
      logic                acc;        // add square into the running sum
      logic                norm_step;  // one leading-zero search step
      logic                load_n;     // load word count into normalizer
      logic                mant_load;  // take mantissa from normalizer
      logic                log_step;   // one squaring iteration
      logic                swap;       // save log of sum
      logic                diff;       // form level difference
      logic                scale;      // multiply by dB scale
      logic                out_load;   // load result register
      logic [STEP_W-1:0]   step;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic blk_end;
      logic sum_zero;
   } status_type;

endpackage

FILE: hdl/rlm_dp.sv
// ----------------------------------------------------------------------------
// rlm_dp
// Datapath: square/accumulate, leading-zero normalizer, iterative log2 by
// mantissa squaring, dB scaling and the result register.
// ----------------------------------------------------------------------------
module rlm_dp #(
   parameter int BLOCK_WORDS = rlm_pkg::BLOCK_WORDS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  rlm_pkg::cmd_type                      cmd,
   input  logic signed [rlm_pkg::SAMPLE_W-1:0]   req_sample,
   input  logic                                  req_last,
   output rlm_pkg::status_type                   status,
   output logic signed [rlm_pkg::DB_W-1:0]       rsp_level_db
);

   logic signed [rlm_pkg::MUL_W-1:0]     mul_a_s;
   logic signed [rlm_pkg::MUL_W-1:0]     mul_b_s;
   logic signed [2*rlm_pkg::MUL_W-1:0]   mul_p_s;

   logic [rlm_pkg::PROD_W-1:0]   prod_ff;
   logic                         last_ff;

   logic [rlm_pkg::SUM_W-1:0]    sum_ff;
   logic [rlm_pkg::SUM_W:0]      sum_wide;
   logic [rlm_pkg::SUM_W-1:0]    sum_new;
   logic [rlm_pkg::CNT_W-1:0]    count_ff;
   logic [rlm_pkg::CNT_W-1:0]    n_next;
   logic [rlm_pkg::CNT_W-1:0]    n_hold_ff;
   logic                         silent_ff;

   logic [rlm_pkg::NORM_W-1:0]   x_ff;
   logic [rlm_pkg::NORM_W-1:0]   x_shift;
   logic [rlm_pkg::INT_W-1:0]    lz_ff;
   logic [rlm_pkg::INT_W-1:0]    lz_amt;
   logic                         norm_hit;

   logic [rlm_pkg::MANT_W-1:0]   m_ff;
   logic [rlm_pkg::MANT_W-1:0]   m_next;
   logic [rlm_pkg::MANT_W:0]     sq_top;
   logic                         frac_bit;
   logic [rlm_pkg::FRAC_W-1:0]   frac_ff;

   logic [rlm_pkg::LOG_W-1:0]    lcur;
   logic [rlm_pkg::LOG_W-1:0]    lsum_ff;
   logic signed [rlm_pkg::DIFF_W-1:0] diff_s;
   logic [rlm_pkg::MAG_W-1:0]    mag_ff;
   logic                         neg_ff;
   logic [rlm_pkg::DB_W-1:0]     q;
   logic signed [rlm_pkg::DB_W-1:0] level_ff;

   // Shared multiplier, operands picked by the controller
   always_comb begin
      unique case (cmd.mul_sel)
         rlm_pkg::MUL_SQUARE: begin
            mul_a_s = {req_sample[rlm_pkg::SAMPLE_W-1], req_sample};
            mul_b_s = {req_sample[rlm_pkg::SAMPLE_W-1], req_sample};
         end
         rlm_pkg::MUL_MANT: begin
            mul_a_s = $signed({2'b00, m_ff});
            mul_b_s = $signed({2'b00, m_ff});
         end
         rlm_pkg::MUL_SCALE: begin
            mul_a_s = $signed({10'b0, mag_ff});
            mul_b_s = $signed({7'b0, rlm_pkg::DB_K});
         end
         default: begin
            mul_a_s = '0;
            mul_b_s = '0;
         end
      endcase
   end

   assign mul_p_s = mul_a_s * mul_b_s;

   // Product register: sample square or scaled level
   always_ff @(posedge clock) begin
      if (cmd.take || cmd.scale) begin
         prod_ff <= mul_p_s[rlm_pkg::PROD_W-1:0];
      end
      if (cmd.take) begin
         last_ff <= req_last;
      end
   end

   // Saturating accumulate and block end detect
   always_comb begin
      sum_wide = {1'b0, sum_ff}
               + (rlm_pkg::SUM_W+1)'(prod_ff[rlm_pkg::PROD_W-1:rlm_pkg::SQ_SHIFT]);
      sum_new  = sum_wide[rlm_pkg::SUM_W] ? '1 : sum_wide[rlm_pkg::SUM_W-1:0];
      n_next   = count_ff + 1'b1;
      status.blk_end  = last_ff || (n_next >= rlm_pkg::CNT_W'(BLOCK_WORDS));
      status.sum_zero = (sum_new == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
      end else if (cmd.acc) begin
         if (status.blk_end) begin
            sum_ff   <= '0;
            count_ff <= '0;
         end else begin
            sum_ff   <= sum_new;
            count_ff <= n_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.acc) begin
         n_hold_ff <= n_next;
         silent_ff <= status.sum_zero;
      end
   end

   // Leading-zero search: halving shift widths, one per step
   always_comb begin
      norm_hit = 1'b0;
      x_shift  = x_ff;
      lz_amt   = '0;
      unique case (cmd.step)
         4'd0: begin
            norm_hit = (x_ff[63:32] == '0);
            x_shift  = {x_ff[31:0], 32'b0};
            lz_amt   = 6'd32;
         end
         4'd1: begin
            norm_hit = (x_ff[63:48] == '0);
            x_shift  = {x_ff[47:0], 16'b0};
            lz_amt   = 6'd16;
         end
         4'd2: begin
            norm_hit = (x_ff[63:56] == '0);
            x_shift  = {x_ff[55:0], 8'b0};
            lz_amt   = 6'd8;
         end
         4'd3: begin
            norm_hit = (x_ff[63:60] == '0);
            x_shift  = {x_ff[59:0], 4'b0};
            lz_amt   = 6'd4;
         end
         4'd4: begin
            norm_hit = (x_ff[63:62] == '0);
            x_shift  = {x_ff[61:0], 2'b0};
            lz_amt   = 6'd2;
         end
         4'd5: begin
            norm_hit = ~x_ff[63];
            x_shift  = {x_ff[62:0], 1'b0};
            lz_amt   = 6'd1;
         end
         default: begin
            norm_hit = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.acc) begin
         x_ff  <= rlm_pkg::NORM_W'(sum_new);
         lz_ff <= '0;
      end else if (cmd.load_n) begin
         x_ff  <= rlm_pkg::NORM_W'(n_hold_ff);
         lz_ff <= '0;
      end else if (cmd.norm_step && norm_hit) begin
         x_ff  <= x_shift;
         lz_ff <= lz_ff + lz_amt;
      end
   end

   // Fraction bits by repeated squaring of the Q1.30 mantissa
   always_comb begin
      sq_top   = mul_p_s[rlm_pkg::MANT_SHIFT+rlm_pkg::MANT_W:rlm_pkg::MANT_SHIFT];
      frac_bit = sq_top[rlm_pkg::MANT_W];
      m_next   = frac_bit ? sq_top[rlm_pkg::MANT_W:1] : sq_top[rlm_pkg::MANT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.mant_load) begin
         m_ff    <= x_ff[rlm_pkg::NORM_W-1:rlm_pkg::NORM_W-rlm_pkg::MANT_W];
         frac_ff <= '0;
      end else if (cmd.log_step) begin
         m_ff    <= m_next;
         frac_ff <= {frac_ff[rlm_pkg::FRAC_W-2:0], frac_bit};
      end
   end

   // log2 in Q16; integer part is 63 minus leading zeros
   assign lcur = {~lz_ff, frac_ff};

   always_ff @(posedge clock) begin
      if (cmd.swap) begin
         lsum_ff <= lcur;
      end
   end

   // Level difference log2(sum) - log2(n) - 22, split into sign and magnitude
   assign diff_s = $signed({2'b00, lsum_ff}) - $signed({2'b00, lcur})
                 - $signed(rlm_pkg::DIFF_W'(rlm_pkg::LOG_OFFSET << rlm_pkg::FRAC_W));

   always_ff @(posedge clock) begin
      if (cmd.diff) begin
         neg_ff <= diff_s[rlm_pkg::DIFF_W-1];
         mag_ff <= diff_s[rlm_pkg::DIFF_W-1] ? rlm_pkg::MAG_W'(-diff_s)
                                             : rlm_pkg::MAG_W'(diff_s);
      end
   end

   // Result: truncated magnitude with sign restored
   assign q = prod_ff[rlm_pkg::DB_SHIFT+rlm_pkg::DB_W-1:rlm_pkg::DB_SHIFT];

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         if (silent_ff) begin
            level_ff <= rlm_pkg::SILENT_DB;
         end else if (neg_ff) begin
            level_ff <= -$signed(q);
         end else begin
            level_ff <= $signed(q);
         end
      end
   end

   assign rsp_level_db = level_ff;

endmodule

FILE: hdl/rlm_ctrl.sv
// ----------------------------------------------------------------------------
// rlm_ctrl
// Controller: sequences accumulate, two log passes, scaling and the
// result handshake.
// ----------------------------------------------------------------------------
module rlm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rlm_pkg::status_type   status,
   output rlm_pkg::cmd_type      cmd
);

   rlm_pkg::state_type            state_ff, state_in;
   logic [rlm_pkg::STEP_W-1:0]    cnt_ff, cnt_in;
   logic                          pass_ff, pass_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pass_in      = pass_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         rlm_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = rlm_pkg::ST_ACC;
            end
         end
         rlm_pkg::ST_ACC: begin
            cnt_in  = '0;
            pass_in = 1'b0;
            if (!status.blk_end) begin
               state_in = rlm_pkg::ST_IDLE;
            end else if (status.sum_zero) begin
               state_in = rlm_pkg::ST_OUT;
            end else begin
               state_in = rlm_pkg::ST_NORM;
            end
         end
         rlm_pkg::ST_NORM: begin
            if (cnt_ff == rlm_pkg::STEP_W'(rlm_pkg::NORM_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = rlm_pkg::ST_MANT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         rlm_pkg::ST_MANT: begin
            state_in = rlm_pkg::ST_LOG;
         end
         rlm_pkg::ST_LOG: begin
            if (cnt_ff == rlm_pkg::STEP_W'(rlm_pkg::LOG_ITERS - 1)) begin
               cnt_in   = '0;
               state_in = pass_ff ? rlm_pkg::ST_DIFF : rlm_pkg::ST_SWAP;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         rlm_pkg::ST_SWAP: begin
            pass_in  = 1'b1;
            state_in = rlm_pkg::ST_NORM;
         end
         rlm_pkg::ST_DIFF: begin
            state_in = rlm_pkg::ST_SCALE;
         end
         rlm_pkg::ST_SCALE: begin
            state_in = rlm_pkg::ST_OUT;
         end
         rlm_pkg::ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = rlm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rlm_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs and datapath commands
   always_comb begin
      cmd         = '0;
      cmd.mul_sel = rlm_pkg::MUL_SQUARE;
      cmd.step    = cnt_ff;
      req_ready   = 1'b0;
      unique case (state_ff)
         rlm_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.take  = req_valid;
         end
         rlm_pkg::ST_ACC: begin
            cmd.acc = 1'b1;
         end
         rlm_pkg::ST_NORM: begin
            cmd.norm_step = 1'b1;
         end
         rlm_pkg::ST_MANT: begin
            cmd.mant_load = 1'b1;
         end
         rlm_pkg::ST_LOG: begin
            cmd.mul_sel  = rlm_pkg::MUL_MANT;
            cmd.log_step = 1'b1;
         end
         rlm_pkg::ST_SWAP: begin
            cmd.swap   = 1'b1;
            cmd.load_n = 1'b1;
         end
         rlm_pkg::ST_DIFF: begin
            cmd.diff = 1'b1;
         end
         rlm_pkg::ST_SCALE: begin
            cmd.mul_sel = rlm_pkg::MUL_SCALE;
            cmd.scale   = 1'b1;
         end
         rlm_pkg::ST_OUT: begin
            cmd.out_load = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rlm_pkg::ST_IDLE;
         cnt_ff       <= '0;
         pass_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: hdl/rms_level_meter_db.sv
// ----------------------------------------------------------------------------
// rms_level_meter_db
// Block RMS level meter giving 10*log10(mean square) in whole decibels.
// ----------------------------------------------------------------------------
// Each signed microphone word is squared on the shared multiplier and the
// square registered, then added in the saturating 60-bit accumulate. For the
// word that closes a block (last set, or the BLOCK_WORDS-th word), before its
// result is loaded the leading-zero search runs 6 steps and the log2 fraction
// takes 16 squaring iterations on the shared multiplier, done once for the sum
// and once for the word count, followed by a difference and a scaling step.
// An all-zero block skips the log and gives -240. The result sits in an
// output register, so new words are taken while it waits for rsp_ready;
// a closing word waits only if the previous result has not been taken yet.
// ----------------------------------------------------------------------------
module rms_level_meter_db #(
   parameter int BLOCK_WORDS = rlm_pkg::BLOCK_WORDS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [rlm_pkg::SAMPLE_W-1:0]   req_sample,
   input  logic                                  req_last,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [rlm_pkg::DB_W-1:0]       rsp_level_db
);

   rlm_pkg::cmd_type      cmd;
   rlm_pkg::status_type   status;

   // Sequencer
   rlm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Arithmetic
   rlm_dp #(
      .BLOCK_WORDS (BLOCK_WORDS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .req_sample   (req_sample),
      .req_last     (req_last),
      .status       (status),
      .rsp_level_db (rsp_level_db)
   );

`ifndef SYNTH
   // Accumulate cycle always follows an input transfer
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input taken in the accumulate cycle");

   // A loaded result is presented next cycle
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid)
      else $error("result load not presented");

   // Presented level stays within the meter range
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_level_db >= rlm_pkg::SILENT_DB &&
                     rsp_level_db <= rlm_pkg::DB_MAX))
      else $error("level out of range");
`endif

endmodule
